// ----- rtl/rpa_pkg.sv -----
// shared types and constants for the two-resource placement allocator
// no dependencies; imported by every rtl file of the block
package rpa_pkg;

    localparam int FUNC_W = 2;
    localparam int CRIT_W = 2;
    localparam int SLOT_W = 6;
    localparam int CPU_W  = 16;
    localparam int MEM_W  = 20;
    localparam int SEL_W  = 3;
    localparam int STAT_W = 3;

    localparam int NUM_MACHINES_DEF = 8;
    localparam int JOB_SLOTS_DEF    = 64;
    localparam int NUM_CRITERIA     = 2;

    localparam logic [CPU_W-1:0] CPU_MAX = '1;
    localparam logic [MEM_W-1:0] MEM_MAX = '1;

    localparam logic [FUNC_W-1:0] FUNC_PLACE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd2;

    localparam logic [CRIT_W-1:0] CRIT_CPU = 2'd0;
    localparam logic [CRIT_W-1:0] CRIT_MEM = 2'd1;

    typedef enum logic [STAT_W-1:0] {
        STAT_PLACED  = 3'd0,
        STAT_NOFIT   = 3'd1,
        STAT_BADCRIT = 3'd2,
        STAT_STOPPED = 3'd3,
        STAT_NOTRUN  = 3'd4,
        STAT_LOADED  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_COMMIT,
        ST_STOP_UPD,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        TBL_IDLE,
        TBL_CLR,
        TBL_SCAN,
        TBL_TAKE,
        TBL_GIVE,
        TBL_LOAD
    } t_tbl_op;

    typedef struct packed {
        t_tbl_op          op;
        logic             key_mem;
        logic [CPU_W-1:0] cpu;
        logic [MEM_W-1:0] mem;
    } t_tbl_cmd;

endpackage

// ----- rtl/rpa_job_ram.sv -----
// job table memory: running flag, host machine and demands per job slot
// one write port, one registered read port; uses rpa_pkg
module rpa_job_ram
    import rpa_pkg::*;
#(
    parameter int JOB_SLOTS = JOB_SLOTS_DEF,
    parameter int SW        = 6,
    parameter int MW        = 3
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [SW-1:0]    i_wr_addr,
    input  logic             i_wr_run,
    input  logic [MW-1:0]    i_wr_mach,
    input  logic [CPU_W-1:0] i_wr_cpu,
    input  logic [MEM_W-1:0] i_wr_mem,
    input  logic [SW-1:0]    i_rd_addr,
    output logic             o_rd_run,
    output logic [MW-1:0]    o_rd_mach,
    output logic [CPU_W-1:0] o_rd_cpu,
    output logic [MEM_W-1:0] o_rd_mem
);

    localparam int EW = 1 + MW + CPU_W + MEM_W;

    logic [EW-1:0] r_ram [JOB_SLOTS];
    logic [EW-1:0] r_rd_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_ram[i_wr_addr] <= {i_wr_run, i_wr_mach, i_wr_cpu, i_wr_mem};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_q <= r_ram[i_rd_addr];
    end

    assign {o_rd_run, o_rd_mach, o_rd_cpu, o_rd_mem} = r_rd_q;

endmodule

// ----- rtl/rpa_mach_tbl.sv -----
// machine table with the shared fit/compare unit and the free-amount updater
// one entry is read per cycle at i_idx; uses rpa_pkg
module rpa_mach_tbl
    import rpa_pkg::*;
#(
    parameter int NUM_MACHINES = NUM_MACHINES_DEF,
    parameter int MW           = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_tbl_cmd      i_cmd,
    input  logic [MW-1:0] i_idx,
    output logic          o_best_valid,
    output logic [MW-1:0] o_best_idx
);

    logic [NUM_MACHINES-1:0] r_loaded;
    logic [CPU_W-1:0]        r_free_cpu [NUM_MACHINES];
    logic [MEM_W-1:0]        r_free_mem [NUM_MACHINES];
    logic                    r_best_valid;
    logic [MW-1:0]           r_best_idx;
    logic [MEM_W-1:0]        r_best_key;

    logic [CPU_W-1:0] rd_cpu;
    logic [MEM_W-1:0] rd_mem;
    logic             fit;
    logic [MEM_W-1:0] key;
    logic             better;
    logic [CPU_W:0]   cpu_sum;
    logic [MEM_W:0]   mem_sum;
    logic [CPU_W-1:0] cpu_give;
    logic [MEM_W-1:0] mem_give;

    always_comb begin
        rd_cpu   = r_free_cpu[i_idx];
        rd_mem   = r_free_mem[i_idx];
        fit      = r_loaded[i_idx] && (rd_cpu >= i_cmd.cpu) && (rd_mem >= i_cmd.mem);
        key      = i_cmd.key_mem ? rd_mem : MEM_W'(rd_cpu);
        // strict compare keeps the lowest index on a tie
        better   = fit && (!r_best_valid || (key > r_best_key));
        cpu_sum  = {1'b0, rd_cpu} + {1'b0, i_cmd.cpu};
        mem_sum  = {1'b0, rd_mem} + {1'b0, i_cmd.mem};
        cpu_give = cpu_sum[CPU_W] ? CPU_MAX : cpu_sum[CPU_W-1:0];
        mem_give = mem_sum[MEM_W] ? MEM_MAX : mem_sum[MEM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded     <= '0;
            r_best_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                TBL_CLR:  r_best_valid <= 1'b0;
                TBL_SCAN: if (better) r_best_valid <= 1'b1;
                TBL_LOAD: r_loaded[i_idx] <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            TBL_SCAN: begin
                if (better) begin
                    r_best_idx <= i_idx;
                    r_best_key <= key;
                end
            end
            TBL_TAKE: begin
                r_free_cpu[i_idx] <= rd_cpu - i_cmd.cpu;
                r_free_mem[i_idx] <= rd_mem - i_cmd.mem;
            end
            TBL_GIVE: begin
                r_free_cpu[i_idx] <= cpu_give;
                r_free_mem[i_idx] <= mem_give;
            end
            TBL_LOAD: begin
                r_free_cpu[i_idx] <= i_cmd.cpu;
                r_free_mem[i_idx] <= i_cmd.mem;
            end
            default: ;
        endcase
    end

    assign o_best_valid = r_best_valid;
    assign o_best_idx   = r_best_idx;

endmodule

// ----- rtl/two_resource_placement_allocator.sv -----
// two-resource placement allocator: input word in, one status word out per operation
// sequencer around rpa_mach_tbl and rpa_job_ram; uses rpa_pkg
//
// input channel i_in_valid / o_in_ready carries an operation word: place (func 0),
// stop (func 1) or load machine capacity (func 2); func 3 is dropped with no result.
// output channel o_out_valid / i_out_ready carries status and chosen machine.
// one operation is in flight at a time; o_in_ready is high only when the sequencer
// is idle. the output register lets a new word be taken while a result waits.
// steps before the done state, which makes the result valid and returns to idle:
//   place: decode, scan one machine per cycle through the single comparator, commit
//   stop:  decode with one job table read, one free-amount update
//   load, bad criteria, out-of-range slot: decode only
// after reset the job table is swept to mark every slot idle, one slot per cycle,
// with o_in_ready low throughout; machines reset to unloaded.
// if the receiver stalls, a finished result waits in the sequencer until the output
// register frees up, and no new word is taken meanwhile.
module two_resource_placement_allocator
    import rpa_pkg::*;
#(
    parameter int NUM_MACHINES = NUM_MACHINES_DEF,
    parameter int JOB_SLOTS    = JOB_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [CRIT_W-1:0] i_criteria,
    input  logic [SLOT_W-1:0] i_job_slot,
    input  logic [CPU_W-1:0]  i_cpu_demand,
    input  logic [MEM_W-1:0]  i_mem_demand,
    input  logic [SEL_W-1:0]  i_machine_sel,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [SEL_W-1:0]  o_chosen_machine
);

    localparam int MW  = (NUM_MACHINES > 1) ? $clog2(NUM_MACHINES) : 1;
    localparam int SW  = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
    localparam int XSW = (SW > SLOT_W) ? SW : SLOT_W;
    localparam int XMW = (MW > SEL_W) ? MW : SEL_W;

    t_state r_state, n_state;
    logic [MW-1:0]     r_idx, n_idx;
    logic [SW-1:0]     r_clr, n_clr;
    t_status           r_pst, n_pst;
    logic [MW-1:0]     r_pch, n_pch;
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_o_status, n_o_status;
    logic [SEL_W-1:0]  r_o_chosen, n_o_chosen;

    logic [FUNC_W-1:0] r_func;
    logic [CRIT_W-1:0] r_crit;
    logic [SLOT_W-1:0] r_slot;
    logic [CPU_W-1:0]  r_cpu;
    logic [MEM_W-1:0]  r_mem;
    logic [SEL_W-1:0]  r_sel;

    logic             in_accept;
    logic             slot_ok;
    logic             sel_ok;
    logic [XSW-1:0]   slot_x;
    logic [SW-1:0]    slot_idx;
    logic [XMW-1:0]   sel_x;
    logic [XMW-1:0]   ch_x;
    t_tbl_cmd         tbl_cmd;
    logic [MW-1:0]    tbl_idx;
    logic             best_valid;
    logic [MW-1:0]    best_idx;
    logic             ram_we;
    logic [SW-1:0]    ram_wr_addr;
    logic             ram_wr_run;
    logic [MW-1:0]    ram_wr_mach;
    logic             rd_run;
    logic [MW-1:0]    rd_mach;
    logic [CPU_W-1:0] rd_cpu;
    logic [MEM_W-1:0] rd_mem;

    rpa_mach_tbl #(
        .NUM_MACHINES (NUM_MACHINES),
        .MW           (MW)
    ) u_mach_tbl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (tbl_cmd),
        .i_idx        (tbl_idx),
        .o_best_valid (best_valid),
        .o_best_idx   (best_idx)
    );

    rpa_job_ram #(
        .JOB_SLOTS (JOB_SLOTS),
        .SW        (SW),
        .MW        (MW)
    ) u_job_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_run  (ram_wr_run),
        .i_wr_mach (ram_wr_mach),
        .i_wr_cpu  (r_cpu),
        .i_wr_mem  (r_mem),
        .i_rd_addr (slot_idx),
        .o_rd_run  (rd_run),
        .o_rd_mach (rd_mach),
        .o_rd_cpu  (rd_cpu),
        .o_rd_mem  (rd_mem)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        slot_x   = XSW'(r_slot);
        slot_idx = slot_x[SW-1:0];
        sel_x    = XMW'(r_sel);
        ch_x     = XMW'(r_pch);
        slot_ok  = int'(r_slot) < JOB_SLOTS;
        sel_ok   = int'(r_sel) < NUM_MACHINES;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_idx       <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pst      <= n_pst;
        r_pch      <= n_pch;
        r_o_status <= n_o_status;
        r_o_chosen <= n_o_chosen;
        if (in_accept) begin
            r_func <= i_func;
            r_crit <= i_criteria;
            r_slot <= i_job_slot;
            r_cpu  <= i_cpu_demand;
            r_mem  <= i_mem_demand;
            r_sel  <= i_machine_sel;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_clr        = r_clr;
        n_pst        = r_pst;
        n_pch        = r_pch;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_o_status   = r_o_status;
        n_o_chosen   = r_o_chosen;
        tbl_cmd.op      = TBL_IDLE;
        tbl_cmd.key_mem = (r_crit == CRIT_MEM);
        tbl_cmd.cpu     = r_cpu;
        tbl_cmd.mem     = r_mem;
        tbl_idx      = r_idx;
        ram_we       = 1'b0;
        ram_wr_addr  = slot_idx;
        ram_wr_run   = 1'b0;
        ram_wr_mach  = rd_mach;

        unique case (r_state)
            ST_CLEAR: begin
                ram_we      = 1'b1;
                ram_wr_addr = r_clr;
                n_clr       = r_clr + 1'b1;
                if (r_clr == SW'(JOB_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_pch   = '0;
                n_state = ST_DONE;
                case (r_func)
                    FUNC_PLACE: begin
                        if (r_crit >= NUM_CRITERIA) begin
                            n_pst = STAT_BADCRIT;
                        end else if (!slot_ok) begin
                            n_pst = STAT_NOFIT;
                        end else begin
                            tbl_cmd.op = TBL_CLR;
                            n_idx      = '0;
                            n_state    = ST_SCAN;
                        end
                    end
                    FUNC_STOP: begin
                        // job table read of r_slot lands in the next cycle
                        if (!slot_ok) begin
                            n_pst = STAT_NOTRUN;
                        end else begin
                            n_state = ST_STOP_UPD;
                        end
                    end
                    FUNC_LOAD: begin
                        if (sel_ok) begin
                            tbl_cmd.op = TBL_LOAD;
                            tbl_idx    = sel_x[MW-1:0];
                        end
                        n_pst = STAT_LOADED;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN: begin
                tbl_cmd.op = TBL_SCAN;
                if (r_idx == MW'(NUM_MACHINES - 1)) begin
                    n_state = ST_COMMIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_COMMIT: begin
                n_state = ST_DONE;
                if (best_valid) begin
                    tbl_cmd.op  = TBL_TAKE;
                    tbl_idx     = best_idx;
                    ram_we      = 1'b1;
                    ram_wr_run  = 1'b1;
                    ram_wr_mach = best_idx;
                    n_pst       = STAT_PLACED;
                    n_pch       = best_idx;
                end else begin
                    n_pst = STAT_NOFIT;
                end
            end
            ST_STOP_UPD: begin
                n_state = ST_DONE;
                if (rd_run) begin
                    tbl_cmd.op = TBL_GIVE;
                    tbl_cmd.cpu = rd_cpu;
                    tbl_cmd.mem = rd_mem;
                    tbl_idx    = rd_mach;
                    ram_we     = 1'b1;
                    n_pst      = STAT_STOPPED;
                end else begin
                    n_pst = STAT_NOTRUN;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_pst;
                    n_o_chosen  = ch_x[SEL_W-1:0];
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_chosen_machine = r_o_chosen;

    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == ST_DECODE)
        else $error("accepted word did not enter decode");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !i_out_ready)
        |=> (r_state == ST_DONE && r_out_valid))
        else $error("pending result lost while output stalled");

    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT && best_valid) |-> int'(best_idx) < NUM_MACHINES)
        else $error("chosen machine beyond table");

    a_stop_host_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STOP_UPD && rd_run) |-> int'(rd_mach) < NUM_MACHINES)
        else $error("running job names a machine beyond table");

    a_reset_clears: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> (r_state == ST_CLEAR && !o_out_valid && !o_in_ready))
        else $error("reset did not start the job table sweep");

endmodule
